/* rtl/jse_pkg.sv */
package jse_pkg;

  localparam int SEQ_MAX = 6;
  localparam int CNT_W = 3;
  localparam int FILL_W = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [FILL_W-1:0] CAP_RESET = 16'hFFFF;

  // register index codes (word address above the byte offset)
  localparam logic REG_OUT_CAPACITY = 1'b0;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       string_done;
    logic       status;
  } result_t;

  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] chars;
    logic [CNT_W-1:0]        len;
  } esc_t;

  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    result_t [SEQ_MAX-1:0]      entry;
  } load_t;

  typedef struct packed {
    logic             can_load;
    logic [CNT_W-1:0] cnt;
  } buf_stat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = CH_ZERO + {4'd0, nib};
    end else begin
      d = CH_LOW_A + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

/* rtl/jse_if.sv */
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       run_last;
  logic       string_done;
  logic       status;

  modport source (output valid, output out_char, output char_valid, output run_last,
                  output string_done, output status, input ready);
  modport sink (input valid, input out_char, input char_valid, input run_last,
                input string_done, input status, output ready);
endinterface

/* rtl/jse_cfg.sv */
module jse_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jse_pkg::ADDR_W-1:0]   paddr,
  input  logic [jse_pkg::DATA_W-1:0]   pwdata,
  output logic [jse_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [jse_pkg::FILL_W-1:0]   out_capacity
);

  logic hit;

  assign hit = (paddr[jse_pkg::ADDR_W-1:2] == jse_pkg::REG_OUT_CAPACITY);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= jse_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && hit) begin
      out_capacity <= pwdata[jse_pkg::FILL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(jse_pkg::DATA_W-jse_pkg::FILL_W){1'b0}}, out_capacity};
    end
  end

endmodule

/* rtl/jse_escape.sv */
module jse_escape (
  input  logic [7:0]      in_byte,
  output jse_pkg::esc_t   esc
);

  logic [7:0] second;

  always_comb begin
    case (in_byte)
      jse_pkg::CH_QUOTE:  second = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BSLASH: second = jse_pkg::CH_BSLASH;
      jse_pkg::CH_LF:     second = jse_pkg::CH_LOW_N;
      jse_pkg::CH_CR:     second = jse_pkg::CH_LOW_R;
      jse_pkg::CH_TAB:    second = jse_pkg::CH_LOW_T;
      jse_pkg::CH_BS:     second = jse_pkg::CH_LOW_B;
      jse_pkg::CH_FF:     second = jse_pkg::CH_LOW_F;
      default:            second = jse_pkg::CH_NUL;
    endcase
  end

  always_comb begin
    esc = '0;
    if (second != jse_pkg::CH_NUL) begin
      // short two-byte escape
      esc.chars[0] = jse_pkg::CH_BSLASH;
      esc.chars[1] = second;
      esc.len = 3'd2;
    end else if (in_byte < jse_pkg::CTRL_LIMIT) begin
      // \u00xx form
      esc.chars[0] = jse_pkg::CH_BSLASH;
      esc.chars[1] = jse_pkg::CH_LOW_U;
      esc.chars[2] = jse_pkg::CH_ZERO;
      esc.chars[3] = jse_pkg::CH_ZERO;
      esc.chars[4] = jse_pkg::hex_digit(in_byte[7:4]);
      esc.chars[5] = jse_pkg::hex_digit(in_byte[3:0]);
      esc.len = 3'd6;
    end else begin
      esc.chars[0] = in_byte;
      esc.len = 3'd1;
    end
  end

endmodule

/* rtl/jse_emit.sv */
module jse_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  jse_pkg::load_t      load_seq,
  output jse_pkg::buf_stat_t  bstat,
  jse_out_if.source           result_out
);

  logic [jse_pkg::CNT_W-1:0]            cnt;
  jse_pkg::result_t [jse_pkg::SEQ_MAX-1:0] seq;
  jse_pkg::result_t                     out_data;
  logic                                 out_valid;
  logic                                 out_free;
  logic                                 emit;

  assign out_free = !out_valid || result_out.ready;
  assign emit = (cnt != '0) && out_free;

  assign bstat.cnt = cnt;
  assign bstat.can_load = (cnt == '0) || ((cnt == 3'd1) && emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= load_seq.cnt;
      end else if (emit) begin
        cnt <= cnt - 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // shift line: head entry always goes out next
  always_ff @(posedge clk) begin
    if (load) begin
      seq <= load_seq.entry;
    end else if (emit) begin
      for (int i = 0; i < jse_pkg::SEQ_MAX - 1; i++) begin
        seq[i] <= seq[i+1];
      end
      seq[jse_pkg::SEQ_MAX-1] <= '0;
    end
    if (emit) begin
      out_data <= seq[0];
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.out_char = out_data.out_char;
  assign result_out.char_valid = out_data.char_valid;
  assign result_out.run_last = out_data.run_last;
  assign result_out.string_done = out_data.string_done;
  assign result_out.status = out_data.status;

endmodule

/* rtl/json_string_escaper_unit.sv */
// Streaming JSON string escaper. Each input item is one string byte; byte 0
// ends the string and answers with a done item whose status flags overflow
// (or a zero capacity). Quote, backslash and the common control characters
// become two-byte escapes, other bytes below 0x20 become six-byte \u00xx
// escapes, and everything else passes unchanged. Bytes whose result would not
// fit in out_capacity (less one byte for the terminator) raise a single overflow
// item and the rest of the string is dropped. Rate: one input item per cycle
// while bytes pass through unescaped and the output is not stalled; an item
// that expands to n result items holds the input until all n have left, because
// the sequence buffer hands one result item per cycle, stall aside, to the output
// register. No clearing pass is needed after reset.
module json_string_escaper_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jse_pkg::ADDR_W-1:0]   paddr,
  input  logic [jse_pkg::DATA_W-1:0]   pwdata,
  output logic [jse_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  jse_in_if.sink                       item_in,
  jse_out_if.source                    result_out
);

  // capacity register from the apb port
  logic [jse_pkg::FILL_W-1:0] out_capacity;

  // per-string state
  logic [jse_pkg::FILL_W-1:0] fill_count, fill_count_next;
  logic                       discarding, discarding_next;

  jse_pkg::esc_t      esc;
  jse_pkg::load_t     load_seq;
  jse_pkg::buf_stat_t bstat;

  logic                       accept;
  logic [jse_pkg::FILL_W:0]   need;
  logic                       fits;

  jse_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .out_capacity (out_capacity)
  );

  // build the escape sequence straight off the input port
  jse_escape u_escape (
    .in_byte (item_in.in_byte),
    .esc     (esc)
  );

  // the buffer takes a new item when empty or when its last entry leaves now
  assign item_in.ready = bstat.can_load;
  assign accept = item_in.valid && item_in.ready;

  // fit check: fill + len + 1 <= capacity, done one bit wider to avoid wrap
  assign need = {1'b0, fill_count} + {{(jse_pkg::FILL_W+1-jse_pkg::CNT_W){1'b0}}, esc.len}
                + {{jse_pkg::FILL_W{1'b0}}, 1'b1};
  assign fits = (need <= {1'b0, out_capacity});

  always_comb begin
    load_seq = '0;
    fill_count_next = fill_count;
    discarding_next = discarding;
    if (item_in.in_byte == jse_pkg::CH_NUL) begin
      // terminator: one done item, then a fresh string
      load_seq.cnt = 3'd1;
      load_seq.entry[0].run_last = 1'b1;
      load_seq.entry[0].string_done = 1'b1;
      load_seq.entry[0].status = discarding || (out_capacity == '0);
      fill_count_next = '0;
      discarding_next = 1'b0;
    end else if (discarding) begin
      // dropped byte, no result items
      load_seq.cnt = '0;
    end else if (!fits) begin
      // overflow reported once, then drop the rest
      load_seq.cnt = 3'd1;
      load_seq.entry[0].run_last = 1'b1;
      load_seq.entry[0].status = 1'b1;
      discarding_next = 1'b1;
    end else begin
      load_seq.cnt = esc.len;
      for (int i = 0; i < jse_pkg::SEQ_MAX; i++) begin
        load_seq.entry[i].out_char = esc.chars[i];
        load_seq.entry[i].char_valid = 1'b1;
        load_seq.entry[i].run_last = (jse_pkg::CNT_W'(i) == (esc.len - 3'd1));
      end
      fill_count_next = fill_count + {{(jse_pkg::FILL_W-jse_pkg::CNT_W){1'b0}}, esc.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      discarding <= discarding_next;
    end
  end

  // sequence buffer and output register
  jse_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_seq   (load_seq),
    .bstat      (bstat),
    .result_out (result_out)
  );

`ifndef SYNTHESIS
  // a dropped byte leaves the count alone
  a_discard_holds_count: assert property (@(posedge clk) disable iff (rst)
    accept && discarding && (item_in.in_byte != jse_pkg::CH_NUL) |=> $stable(fill_count))
    else $error("fill count moved while discarding");

  // terminator resets the string state
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (item_in.in_byte == jse_pkg::CH_NUL) |=> (fill_count == '0) && !discarding)
    else $error("terminator did not clear string state");

  // a dropped byte queues nothing
  a_discard_no_load: assert property (@(posedge clk) disable iff (rst)
    accept && discarding && (item_in.in_byte != jse_pkg::CH_NUL) |=> (bstat.cnt == '0))
    else $error("result items queued for a dropped byte");
`endif

endmodule
